// ----- src/ibdt_pkg.sv -----
// shared types and constants for the inverse block transform
package ibdt_pkg;

   localparam int BLOCK_SIZE = 64;
   localparam int IDX_BITS = 6;

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_LIFT  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic                store_in;
      logic [IDX_BITS-1:0] store_addr;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic [1:0]          rd_lane;
      logic                lift;
      logic                lift_end;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic [1:0]          wr_lane;
      logic                emit;
      logic                emit_last;
   } ctrl_type;

   // base index of line n (0..15) of pass p; line_addr adds element e at the stride of that pass
   function automatic logic [IDX_BITS-1:0] line_base(input logic [1:0] pass,
                                                     input logic [3:0] n);
      logic [IDX_BITS-1:0] b;
      b = '0;
      unique case (pass)
         2'd0:    b = {2'b00, n[3:2], n[1:0]};
         2'd1:    b = {n[1:0], 2'b00, n[3:2]};
         default: b = {n[3:2], n[1:0], 2'b00};
      endcase
      return b;
   endfunction

   function automatic logic [IDX_BITS-1:0] line_addr(input logic [1:0] pass,
                                                     input logic [3:0] n,
                                                     input logic [1:0] e);
      logic [IDX_BITS-1:0] b;
      logic [IDX_BITS-1:0] a;
      b = line_base(pass, n);
      a = b;
      unique case (pass)
         2'd0:    a = b + {e, 4'b0000};
         2'd1:    a = b + {2'b00, e, 2'b00};
         default: a = b + {4'b0000, e};
      endcase
      return a;
   endfunction

endpackage

// ----- src/inverse_block_decorrelating_transform_3d.sv -----
// top level of the 4x4x4 inverse decorrelating transform
// Usage: drive req_coefficient with req_start high; a coefficient transfers
// at each rising edge where req_start is high and req_busy is low. Send the
// 64 coefficients of a block in x+4y+16z order, one per cycle if wished.
// After the 64th, req_busy rises and the block runs 48 line lifts, each a
// read phase, a lift phase and a write phase on the single block store
// port. Then 64 results leave on consecutive cycles, rsp_valid marking
// each and rsp_last the 64th; the first appears after emission begins,
// through the store read register and the output register. The receiver
// cannot stall: each result is on the rsp ports for exactly one cycle.
// Synchronous reset returns the sequencer to loading with a zero count and
// clears the strobes; the block store contents are not cleared.
module inverse_block_decorrelating_transform_3d #(
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  logic signed [31:0] req_coefficient,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_sample,
   output logic               rsp_last
);
   import ibdt_pkg::*;

   ctrl_type ctrl;
   logic     busy_core;

   ibdt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .req_busy  (busy_core),
      .ctrl      (ctrl)
   );

   ibdt_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_coefficient (req_coefficient),
      .rsp_sample      (rsp_sample),
      .rsp_valid       (rsp_valid),
      .rsp_last        (rsp_last)
   );

   assign req_busy = busy_core;

endmodule

// ----- src/ibdt_datapath.sv -----
// block store, line registers and the shared lifting unit
module ibdt_datapath #(
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ibdt_pkg::ctrl_type  ctrl,
   input  logic signed [31:0]  req_coefficient,
   output logic signed [31:0]  rsp_sample,
   output logic                rsp_valid,
   output logic                rsp_last
);
   import ibdt_pkg::*;

   localparam int VB = VALUE_BITS;

   logic [VB-1:0] mem [BLOCK_SIZE];
   logic [VB-1:0] rd_data_ff;
   logic          rd_v_ff;
   logic [1:0]    rd_lane_ff;
   logic [VB-1:0] line_ff [4];
   logic [VB-1:0] line_in [4];
   logic [VB-1:0] wr_data;
   logic [VB-1:0] a0, b0, c0, d0, b1, d1, b2, c1, a1, d2, b3, c2, d3, a2;
   logic          rsp_valid_ff;
   logic          rsp_last_ff;
   logic [31:0]   rsp_sample_ff;
   logic          emit_d_ff;
   logic          emit_last_d_ff;

   function automatic logic [VB-1:0] asr1(input logic [VB-1:0] v);
      return {v[VB-1], v[VB-1:1]};
   endfunction

   always_comb begin
      a0 = line_ff[0];
      b0 = line_ff[1];
      c0 = line_ff[2];
      d0 = line_ff[3];
      // first half of the lifting sequence
      b1 = b0 + asr1(d0);
      d1 = d0 - asr1(b1);
      b2 = b1 + d1;
      c1 = c0 + a0;
      a1 = {a0[VB-2:0], 1'b0} - c1;
      // second half, applied to the line left by the first half
      d2 = {d0[VB-2:0], 1'b0} - b0;
      b3 = b0 + c0;
      c2 = {c0[VB-2:0], 1'b0} - b3;
      d3 = d2 + a0;
      a2 = {a0[VB-2:0], 1'b0} - d3;
      for (int i = 0; i < 4; i++) line_in[i] = line_ff[i];
      if (ctrl.lift) begin
         line_in[0] = a1;
         line_in[1] = b2;
         line_in[2] = c1;
         line_in[3] = d1;
      end else if (ctrl.lift_end) begin
         line_in[0] = a2;
         line_in[1] = b3;
         line_in[2] = c2;
         line_in[3] = d3;
      end else if (rd_v_ff) begin
         line_in[rd_lane_ff] = rd_data_ff;
      end
      wr_data = line_ff[ctrl.wr_lane];
   end

   always_ff @(posedge clock) begin
      if (ctrl.store_in) begin
         mem[ctrl.store_addr] <= VB'(req_coefficient);
      end else if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.emit) rd_data_ff <= mem[ctrl.rd_addr];
      else if (ctrl.rd_en) rd_data_ff <= mem[ctrl.rd_addr];
      rd_lane_ff <= ctrl.rd_lane;
      for (int i = 0; i < 4; i++) line_ff[i] <= line_in[i];
      if (emit_d_ff) rsp_sample_ff <= rd_data_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         emit_d_ff <= 1'b0;
         emit_last_d_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
      end else begin
         rd_v_ff <= ctrl.rd_en;
         emit_d_ff <= ctrl.emit;
         emit_last_d_ff <= ctrl.emit_last;
         rsp_valid_ff <= emit_d_ff;
         rsp_last_ff <= emit_d_ff & emit_last_d_ff;
      end
   end

   assign rsp_sample = rsp_sample_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last = rsp_last_ff;

   a_last_with_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without strobe");
   a_valid_follows_emit: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> ##2 rsp_valid) else $error("emit lost");
   a_no_lift_during_write: assert property (@(posedge clock) disable iff (reset)
      !((ctrl.lift || ctrl.lift_end) && ctrl.wr_en)) else $error("lift during write");

endmodule

// ----- src/ibdt_controller.sv -----
// sequencer: load, three lifting passes over 16 lines each, then emit
module ibdt_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   output ibdt_pkg::ctrl_type ctrl
);
   import ibdt_pkg::*;

   state_type     state_ff, state_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [1:0]    pass_ff, pass_in;
   logic [3:0]    line_ff, line_in;
   logic [2:0]    step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pass_in = pass_ff;
      line_in = line_ff;
      step_in = step_ff;
      ctrl = '0;
      ctrl.rd_addr = line_addr(pass_ff, line_ff, step_ff[1:0]);
      ctrl.rd_lane = step_ff[1:0];
      ctrl.wr_addr = line_addr(pass_ff, line_ff, step_ff[1:0]);
      ctrl.wr_lane = step_ff[1:0];
      ctrl.store_addr = cnt_ff[5:0];
      unique case (state_ff)
         ST_LOAD: begin
            if (req_start) begin
               ctrl.store_in = 1'b1;
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff[5:0] == 6'd63) begin
                  cnt_in = '0;
                  pass_in = '0;
                  line_in = '0;
                  step_in = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // four reads; the last one passes the read data register into the line before the lift
            ctrl.rd_en = (step_ff <= 3'd3);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               step_in = '0;
               state_in = ST_LIFT;
            end
         end
         ST_LIFT: begin
            // lifting sequence split into a lift step and a lift_end step
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd0) begin
               ctrl.lift = 1'b1;
            end else begin
               ctrl.lift_end = 1'b1;
               step_in = '0;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ctrl.wr_en = 1'b1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in = '0;
               line_in = line_ff + 4'd1;
               state_in = ST_READ;
               if (line_ff == 4'd15) begin
                  pass_in = pass_ff + 2'd1;
                  if (pass_ff == 2'd2) begin
                     state_in = ST_EMIT;
                     cnt_in = '0;
                  end
               end
            end
         end
         ST_EMIT: begin
            ctrl.emit = 1'b1;
            ctrl.rd_addr = cnt_ff[5:0];
            ctrl.emit_last = (cnt_ff[5:0] == 6'd63);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff[5:0] == 6'd63) begin
               cnt_in = '0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // tracks the last results through the read and output registers as they leave
   logic [1:0] tail_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
         pass_ff <= '0;
         line_ff <= '0;
         step_ff <= '0;
         tail_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pass_ff <= pass_in;
         line_ff <= line_in;
         step_ff <= step_in;
         tail_ff <= {tail_ff[0], ctrl.emit_last};
      end
   end

   assign req_busy = (state_ff != ST_LOAD);

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_emit_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && cnt_ff[5:0] == 6'd63) |=> state_ff == ST_LOAD)
      else $error("emit did not end");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.store_in |-> state_ff == ST_LOAD) else $error("store while busy");
   a_tail: assert property (@(posedge clock) disable iff (reset)
      tail_ff[1] |-> state_ff == ST_LOAD) else $error("tail overlap");

endmodule
